// ----- rtl/ssc_pkg.sv -----
`timescale 1ns / 1ps
package ssc_pkg;
  localparam int unsigned ElemWidth   = 16;
  localparam int unsigned SumWidth    = 21;
  localparam int unsigned CountWidth  = 17;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned AddrWidth   = 1;
  localparam logic [AddrWidth-1:0] RegTargetSum = 1'b0;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;
endpackage

// ----- rtl/ssc_if.sv -----
`timescale 1ns / 1ps
interface ssc_in_if import ssc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [ElemWidth-1:0] element_value;
  logic                        last_element;
  modport source (output valid, element_value, last_element, input ready);
  modport sink (input valid, element_value, last_element, output ready);
endinterface

interface ssc_out_if import ssc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] subset_count;
  logic                  found;
  modport source (output valid, subset_count, found, input ready);
  modport sink (input valid, subset_count, found, output ready);
endinterface

// ----- rtl/subset_sum_count.sv -----
`timescale 1ns / 1ps
// Subset-sum counter. Elements stream in one per transfer and are held in a
// row of MAX_ELEMENTS cells. The transfer with last_element set starts a
// scan over every subset mask of the loaded set, one mask per cycle; each
// mask travels down the cell row, which forms its sum as a pipeline, and
// the sum leaving the row is compared with target_sum. The input is not
// ready again until the result has been taken from the output port.
// Counting every subset directly gives the same count as pairing the two
// halves' sums. The count saturates at 2^17-1. Elements beyond
// MAX_ELEMENTS are dropped; their last flag still closes the set.
// target_sum sits at byte address 0 of the APB port, reset 0.
module subset_sum_count import ssc_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  ssc_in_if.sink               in_if,
  ssc_out_if.source            out_if
);
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned MaskW = MAX_ELEMENTS + 1;

  logic signed [SumWidth-1:0] target_q;
  logic [CntW-1:0]            total_q, total_d;
  logic [MaskW-1:0]           mask_q, mask_d;
  logic [MaskW-1:0]           limit;
  logic                       mvalid;
  logic [MAX_ELEMENTS:0]      vld_q;
  logic [MAX_ELEMENTS-1:0]    mask_pipe_q [MAX_ELEMENTS];
  logic signed [SumWidth-1:0] sums [MAX_ELEMENTS+1];
  logic [CountWidth-1:0]      count_q, count_d;
  state_e                     state_q, state_d;
  logic                       in_xfer, last_xfer;

  assign pready = 1'b1;
  assign prdata = DataWidth'($unsigned(target_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegTargetSum) begin
      target_q <= pwdata[SumWidth-1:0];
    end
  end

  assign in_if.ready = (state_q == ST_LOAD);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign last_xfer   = in_xfer && in_if.last_element;
  assign limit       = MaskW'(1) << total_d;
  assign mvalid      = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (last_xfer) state_d = ST_SCAN;
      ST_SCAN:  if (mask_q + MaskW'(1) == limit) state_d = ST_DRAIN;
      ST_DRAIN: if (vld_q == '0 && !mvalid) state_d = ST_OUT;
      ST_OUT:   if (out_if.ready) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    total_d = total_q;
    mask_d  = mask_q;
    case (state_q)
      ST_LOAD: begin
        mask_d = '0;
        if (in_xfer && total_q < CntW'(MAX_ELEMENTS)) begin
          total_d = total_q + CntW'(1);
        end
      end
      ST_SCAN:  mask_d = mask_q + MaskW'(1);
      ST_OUT:   if (out_if.ready) total_d = '0;
      default:  mask_d = mask_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (state_q == ST_LOAD && last_xfer) begin
      count_d = '0;
    end else if (vld_q[MAX_ELEMENTS] && sums[MAX_ELEMENTS] == target_q
                 && count_q != '1) begin
      count_d = count_q + CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      total_q <= '0;
      mask_q  <= '0;
      count_q <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      mask_q  <= mask_d;
      count_q <= count_d;
      vld_q   <= {vld_q[MAX_ELEMENTS-1:0], mvalid};
    end
  end

  // Hold the mask alongside its partial sum as it walks down the row.
  always_ff @(posedge clk_i) begin
    mask_pipe_q[0] <= mask_q[MAX_ELEMENTS-1:0];
    for (int k = 1; k < MAX_ELEMENTS; k++) begin
      mask_pipe_q[k] <= mask_pipe_q[k-1];
    end
  end

  // The row input sum is zero; stage k holds the sum over cells below k.
  logic signed [SumWidth-1:0] sum0_q;
  always_ff @(posedge clk_i) begin
    sum0_q <= '0;
  end
  assign sums[0] = sum0_q;

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    ssc_cell u_cell (
      .clk_i  (clk_i),
      .load_i (in_xfer && total_q == CntW'(g)),
      .elem_i (in_if.element_value),
      .use_i  (mask_pipe_q[g][g]),
      .sum_i  (sums[g]),
      .sum_o  (sums[g+1])
    );
  end

  assign out_if.valid        = (state_q == ST_OUT);
  assign out_if.subset_count = count_q;
  assign out_if.found        = (count_q != '0);
endmodule

// ----- rtl/ssc_cell.sv -----
`timescale 1ns / 1ps
// One element slot. During a scan, a partial sum ripples down the row; each
// cell adds its element when its bit of the subset mask is set.
module ssc_cell import ssc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic signed [ElemWidth-1:0] elem_i,
  input  logic                        use_i,
  input  logic signed [SumWidth-1:0]  sum_i,
  output logic signed [SumWidth-1:0]  sum_o
);
  logic signed [ElemWidth-1:0] elem_q;
  logic signed [SumWidth-1:0]  sum_q, sum_d;

  always_comb begin
    sum_d = sum_i;
    if (use_i) begin
      sum_d = sum_i + SumWidth'(elem_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      elem_q <= elem_i;
    end
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;
endmodule
